// ===== hw/rtl/cwk_pkg.sv =====
`timescale 1ns / 1ps
// cwk_pkg: shared types, constants and lookup tables for the well-known-core
// responder. No dependencies; used by every module under hw/rtl.
package cwk_pkg;

	localparam int MAX_MESSAGE_BYTES = 128;
	localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);
	localparam int CMD_DEPTH = 2;
	localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

	localparam logic [3:0] WELL_KNOWN_LEN = 4'd11;
	localparam logic [3:0] CORE_LEN = 4'd4;
	localparam logic [3:0] REPLY_LAST_IDX = 4'd11;
	localparam logic [1:0] COAP_VERSION = 2'd1;

	localparam logic [2:0] REG_GET_CODE = 3'd0;
	localparam logic [2:0] REG_ACK_TYPE = 3'd1;
	localparam logic [2:0] REG_CONTENT_CODE = 3'd2;
	localparam logic [2:0] REG_CONTENT_TYPE_OPTION = 3'd3;
	localparam logic [2:0] REG_LINK_FORMAT_TYPE = 3'd4;
	localparam logic [2:0] REG_MAX_OPTIONS = 3'd5;

	typedef enum logic [1:0] {
		VERDICT_REPLY  = 2'd0,
		VERDICT_REJECT = 2'd1,
		VERDICT_IGNORE = 2'd2
	} verdict_t;

	typedef enum logic [5:0] {
		PH_HEADER   = 6'b000001,
		PH_OPT_HDR  = 6'b000010,
		PH_OPT_VAL  = 6'b000100,
		PH_PAYLOAD  = 6'b001000,
		PH_BAD      = 6'b010000,
		PH_OVERLONG = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} req_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		verdict_t   verdict;
	} rsp_word_t;

	typedef struct packed {
		logic [7:0] get_code;
		logic [1:0] ack_type;
		logic [7:0] content_code;
		logic [3:0] content_type_option;
		logic [7:0] link_format_type;
		logic [3:0] max_options;
	} cfg_t;

	typedef struct packed {
		verdict_t    kind;
		logic [15:0] msg_id;
	} cmd_t;

	function automatic logic [7:0] well_known_byte(input logic [3:0] idx);
		logic [7:0] r;
		case (idx)
			4'd0:    r = 8'h2e;
			4'd1:    r = 8'h77;
			4'd2:    r = 8'h65;
			4'd3:    r = 8'h6c;
			4'd4:    r = 8'h6c;
			4'd5:    r = 8'h2d;
			4'd6:    r = 8'h6b;
			4'd7:    r = 8'h6e;
			4'd8:    r = 8'h6f;
			4'd9:    r = 8'h77;
			4'd10:   r = 8'h6e;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] core_byte(input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0:    r = 8'h63;
			2'd1:    r = 8'h6f;
			2'd2:    r = 8'h72;
			default: r = 8'h65;
		endcase
		return r;
	endfunction

	// "</led>" body, reply bytes 6..11
	function automatic logic [7:0] link_byte(input logic [3:0] idx);
		logic [7:0] r;
		case (idx)
			4'd6:    r = 8'h3c;
			4'd7:    r = 8'h2f;
			4'd8:    r = 8'h6c;
			4'd9:    r = 8'h65;
			4'd10:   r = 8'h64;
			4'd11:   r = 8'h3e;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/coap_wellknown_responder.sv =====
`timescale 1ns / 1ps
// coap_wellknown_responder: top level; configuration registers and the
// front parser, command queue and reply generator. Depends on cwk_pkg.
//
// Usage: message bytes enter as words on req (in_byte, in_last) when push is
// high and full is low; one byte per cycle, in_last on the final byte.
// Results leave on rsp while empty is low and are taken with pop. A request
// for .well-known/core yields twelve reply words, anything else one verdict
// word (1 header rejected, 2 ignored), out_last set on the last word.
// The first result word goes through the queue and the output register once the
// final byte is taken; reply words follow at one per cycle while pop is held.
// Throughput: one byte per cycle; full rises only when two finished messages
// are waiting for the result side, which drains one word per cycle while pop
// is held. A stalled result side holds its word and the parser keeps taking bytes.
// Configuration: cfg_index/cfg_data written when cfg_valid is high
// (cfg_ready is always high); indexes beyond the register list are ignored.
// Reset (arst_n low) clears parser state, queue and output and loads the
// register defaults.
module coap_wellknown_responder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  cwk_pkg::req_word_t req,
	output logic               empty,
	input  logic               pop,
	output cwk_pkg::rsp_word_t rsp,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [7:0]         cfg_data
);

	cwk_pkg::cfg_t cfg_q;
	cwk_pkg::cmd_t cmd;
	cwk_pkg::cmd_t head;
	logic          cmd_push;
	logic          q_empty;
	logic          q_full;
	logic          q_pop;
	logic          acc;

	assign cfg_ready = 1'b1;
	assign full = q_full;
	assign acc = push && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.get_code <= 8'd1;
			cfg_q.ack_type <= 2'd2;
			cfg_q.content_code <= 8'd69;
			cfg_q.content_type_option <= 4'd1;
			cfg_q.link_format_type <= 8'd40;
			cfg_q.max_options <= 4'd8;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				cwk_pkg::REG_GET_CODE:            cfg_q.get_code <= cfg_data;
				cwk_pkg::REG_ACK_TYPE:            cfg_q.ack_type <= cfg_data[1:0];
				cwk_pkg::REG_CONTENT_CODE:        cfg_q.content_code <= cfg_data;
				cwk_pkg::REG_CONTENT_TYPE_OPTION: cfg_q.content_type_option <= cfg_data[3:0];
				cwk_pkg::REG_LINK_FORMAT_TYPE:    cfg_q.link_format_type <= cfg_data;
				cwk_pkg::REG_MAX_OPTIONS:         cfg_q.max_options <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	cwk_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.req      (req),
		.cfg      (cfg_q),
		.cmd_push (cmd_push),
		.cmd      (cmd)
	);

	cwk_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (cmd_push),
		.wr_data (cmd),
		.rd      (q_pop),
		.head    (head),
		.q_empty (q_empty),
		.q_full  (q_full)
	);

	cwk_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.head    (head),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.rsp     (rsp)
	);

endmodule

// ===== hw/rtl/cwk_front.sv =====
`timescale 1ns / 1ps
// cwk_front: per-byte CoAP header/option parser; on the final byte it issues
// one command word to the queue. Depends on cwk_pkg.
module cwk_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               acc,
	input  cwk_pkg::req_word_t req,
	input  cwk_pkg::cfg_t      cfg,
	output logic               cmd_push,
	output cwk_pkg::cmd_t      cmd
);

	cwk_pkg::phase_t            phase_q, phase_d;
	logic [cwk_pkg::POS_W-1:0]  pos_q, pos_d;
	logic [15:0]                msg_id_q, msg_id_d;
	logic [7:0]                 req_code_q, req_code_d;
	logic [3:0]                 opt_count_q, opt_count_d;
	logic [3:0]                 seen_q, seen_d;
	logic [3:0]                 left_q, left_d;
	logic [3:0]                 cidx_q, cidx_d;
	logic [1:0]                 pm_q, pm_d;
	logic                       bad_q, bad_d;
	logic [7:0]                 b;
	logic [3:0]                 len;
	logic [3:0]                 seen_inc;
	logic [3:0]                 left_dec;

	assign b = req.in_byte;
	assign len = b[3:0];
	assign seen_inc = seen_q + 4'd1;
	assign left_dec = left_q - 4'd1;

	always_comb begin
		phase_d = phase_q;
		pos_d = pos_q;
		msg_id_d = msg_id_q;
		req_code_d = req_code_q;
		opt_count_d = opt_count_q;
		seen_d = seen_q;
		left_d = left_q;
		cidx_d = cidx_q;
		pm_d = pm_q;
		bad_d = bad_q;
		cmd.kind = cwk_pkg::VERDICT_IGNORE;
		cmd.msg_id = msg_id_q;

		if (pos_q >= cwk_pkg::POS_W'(cwk_pkg::MAX_MESSAGE_BYTES)) begin
			if (phase_q != cwk_pkg::PH_BAD) begin
				phase_d = cwk_pkg::PH_OVERLONG;
			end
		end else begin
			pos_d = pos_q + cwk_pkg::POS_W'(1);
			unique case (phase_q)
				cwk_pkg::PH_HEADER: begin
					if (pos_q == cwk_pkg::POS_W'(0)) begin
						opt_count_d = b[3:0];
						bad_d = (b[7:6] != cwk_pkg::COAP_VERSION) ||
							(b[3:0] > cfg.max_options);
					end else if (pos_q == cwk_pkg::POS_W'(1)) begin
						req_code_d = b;
					end else if (pos_q == cwk_pkg::POS_W'(2)) begin
						msg_id_d = {b, 8'h00};
					end else begin
						msg_id_d = {msg_id_q[15:8], b};
						if (bad_q) begin
							phase_d = cwk_pkg::PH_BAD;
						end else if (opt_count_q == 4'd0) begin
							phase_d = cwk_pkg::PH_PAYLOAD;
						end else begin
							phase_d = cwk_pkg::PH_OPT_HDR;
						end
					end
				end
				cwk_pkg::PH_OPT_HDR: begin
					cidx_d = 4'd0;
					left_d = len;
					if (seen_q == 4'd0 && len == cwk_pkg::WELL_KNOWN_LEN) pm_d[0] = 1'b1;
					if (seen_q == 4'd1 && len == cwk_pkg::CORE_LEN) pm_d[1] = 1'b1;
					if (len == 4'd0) begin
						seen_d = seen_inc;
						phase_d = (seen_inc == opt_count_q) ?
							cwk_pkg::PH_PAYLOAD : cwk_pkg::PH_OPT_HDR;
					end else begin
						phase_d = cwk_pkg::PH_OPT_VAL;
					end
				end
				cwk_pkg::PH_OPT_VAL: begin
					if (seen_q == 4'd0 && cidx_q < cwk_pkg::WELL_KNOWN_LEN &&
						b != cwk_pkg::well_known_byte(cidx_q)) pm_d[0] = 1'b0;
					if (seen_q == 4'd1 && cidx_q < cwk_pkg::CORE_LEN &&
						b != cwk_pkg::core_byte(cidx_q[1:0])) pm_d[1] = 1'b0;
					cidx_d = cidx_q + 4'd1;
					left_d = left_dec;
					if (left_dec == 4'd0) begin
						seen_d = seen_inc;
						phase_d = (seen_inc == opt_count_q) ?
							cwk_pkg::PH_PAYLOAD : cwk_pkg::PH_OPT_HDR;
					end
				end
				default: begin
				end
			endcase
		end

		cmd.msg_id = msg_id_d;
		if (phase_d == cwk_pkg::PH_BAD) begin
			cmd.kind = cwk_pkg::VERDICT_REJECT;
		end else if (phase_d == cwk_pkg::PH_PAYLOAD && req_code_d == cfg.get_code &&
			opt_count_d == 4'd2 && pm_d == 2'b11) begin
			cmd.kind = cwk_pkg::VERDICT_REPLY;
		end else begin
			cmd.kind = cwk_pkg::VERDICT_IGNORE;
		end
	end

	assign cmd_push = acc && req.in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cwk_pkg::PH_HEADER;
			pos_q <= '0;
			msg_id_q <= '0;
			req_code_q <= '0;
			opt_count_q <= '0;
			seen_q <= '0;
			left_q <= '0;
			cidx_q <= '0;
			pm_q <= '0;
			bad_q <= 1'b0;
		end else if (acc) begin
			if (req.in_last) begin
				phase_q <= cwk_pkg::PH_HEADER;
				pos_q <= '0;
				msg_id_q <= '0;
				req_code_q <= '0;
				opt_count_q <= '0;
				seen_q <= '0;
				left_q <= '0;
				cidx_q <= '0;
				pm_q <= '0;
				bad_q <= 1'b0;
			end else begin
				phase_q <= phase_d;
				pos_q <= pos_d;
				msg_id_q <= msg_id_d;
				req_code_q <= req_code_d;
				opt_count_q <= opt_count_d;
				seen_q <= seen_d;
				left_q <= left_d;
				cidx_q <= cidx_d;
				pm_q <= pm_d;
				bad_q <= bad_d;
			end
		end
	end

endmodule

// ===== hw/rtl/cwk_cmd_queue.sv =====
`timescale 1ns / 1ps
// cwk_cmd_queue: short register queue of command words between the parser
// and the reply generator. Depends on cwk_pkg.
module cwk_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  cwk_pkg::cmd_t wr_data,
	input  logic          rd,
	output cwk_pkg::cmd_t head,
	output logic          q_empty,
	output logic          q_full
);

	cwk_pkg::cmd_t                  mem_q [cwk_pkg::CMD_DEPTH];
	logic [cwk_pkg::CMD_PTR_W-1:0]  wp_q;
	logic [cwk_pkg::CMD_PTR_W-1:0]  rp_q;
	logic [cwk_pkg::CMD_CNT_W-1:0]  cnt_q;
	logic                           do_wr;
	logic                           do_rd;

	assign q_empty = (cnt_q == '0);
	assign q_full = (cnt_q == cwk_pkg::CMD_CNT_W'(cwk_pkg::CMD_DEPTH));
	assign do_wr = wr && !q_full;
	assign do_rd = rd && !q_empty;
	assign head = mem_q[rp_q];

	function automatic logic [cwk_pkg::CMD_PTR_W-1:0] ptr_inc(
		input logic [cwk_pkg::CMD_PTR_W-1:0] p);
		logic [cwk_pkg::CMD_PTR_W-1:0] r;
		if (p == cwk_pkg::CMD_PTR_W'(cwk_pkg::CMD_DEPTH - 1)) r = '0;
		else r = p + cwk_pkg::CMD_PTR_W'(1);
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= ptr_inc(wp_q);
			if (do_rd) rp_q <= ptr_inc(rp_q);
			if (do_wr && !do_rd) cnt_q <= cnt_q + cwk_pkg::CMD_CNT_W'(1);
			else if (do_rd && !do_wr) cnt_q <= cnt_q - cwk_pkg::CMD_CNT_W'(1);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cwk_pkg::CMD_CNT_W'(cwk_pkg::CMD_DEPTH))
		else $error("cmd queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr && !q_full && !(rd && !q_empty)) |=> !q_empty)
		else $error("cmd queue lost a word");
	assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> (wp_q == rp_q))
		else $error("cmd queue pointers disagree when empty");

endmodule

// ===== hw/rtl/cwk_back.sv =====
`timescale 1ns / 1ps
// cwk_back: turns queued command words into result words (one verdict or a
// 12-byte acknowledgement) through an output register. Depends on cwk_pkg.
module cwk_back (
	input  logic               clk,
	input  logic               arst_n,
	input  cwk_pkg::cfg_t      cfg,
	input  cwk_pkg::cmd_t      head,
	input  logic               q_empty,
	output logic               q_pop,
	input  logic               pop,
	output logic               empty,
	output cwk_pkg::rsp_word_t rsp
);

	logic [3:0]         idx_q;
	logic               ovld_q;
	cwk_pkg::rsp_word_t out_q;
	cwk_pkg::rsp_word_t gen;
	logic               load;
	logic               gen_last;

	always_comb begin
		gen.verdict = head.kind;
		gen.out_byte = 8'h00;
		gen_last = 1'b1;
		if (head.kind == cwk_pkg::VERDICT_REPLY) begin
			gen_last = (idx_q == cwk_pkg::REPLY_LAST_IDX);
			unique case (idx_q)
				4'd0:    gen.out_byte = {2'b01, cfg.ack_type, 4'b0001};
				4'd1:    gen.out_byte = cfg.content_code;
				4'd2:    gen.out_byte = head.msg_id[15:8];
				4'd3:    gen.out_byte = head.msg_id[7:0];
				4'd4:    gen.out_byte = {cfg.content_type_option, 4'b0001};
				4'd5:    gen.out_byte = cfg.link_format_type;
				default: gen.out_byte = cwk_pkg::link_byte(idx_q);
			endcase
		end
		gen.out_last = gen_last;
	end

	assign load = !q_empty && (!ovld_q || pop);
	assign q_pop = load && gen_last;
	assign empty = !ovld_q;
	assign rsp = out_q;

	always_ff @(posedge clk) begin
		if (load) out_q <= gen;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			ovld_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= gen_last ? 4'd0 : idx_q + 4'd1;
			end
			if (load) ovld_q <= 1'b1;
			else if (pop) ovld_q <= 1'b0;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= cwk_pkg::REPLY_LAST_IDX)
		else $error("reply index out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 4'd0) |-> (!q_empty && head.kind == cwk_pkg::VERDICT_REPLY))
		else $error("reply in progress without a reply command");
	assert property (@(posedge clk) disable iff (!arst_n)
		(ovld_q && out_q.verdict != cwk_pkg::VERDICT_REPLY) |->
		(out_q.out_last && out_q.out_byte == 8'h00))
		else $error("verdict word malformed");

endmodule
